FILE: hdl/tlfe_pkg.sv
// Shared types, character codes and reply text for the telemetry link frame emitter.
// No dependencies; used by telemetry_link_frame_emitter.
package tlfe_pkg;

  // Beat payloads
  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       sensor_ok;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_beat_t;

  // Link machine
  typedef enum logic [1:0] {
    LINK_WAIT   = 2'd0,
    LINK_IDLE   = 2'd1,
    LINK_STREAM = 2'd2
  } link_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_PREFIX,
    ST_LOAD,
    ST_CONV,
    ST_SCAN,
    ST_DIGIT,
    ST_SEP
  } state_t;

  // Which fixed reply is being sent
  typedef enum logic [1:0] {
    REPLY_SYNC,
    REPLY_DISC,
    REPLY_STOP
  } reply_t;

  // Frame fields, in send order
  typedef enum logic [2:0] {
    FLD_HUM,
    FLD_TEMP,
    FLD_CH3,
    FLD_CH4,
    FLD_COUNT
  } field_t;

  // Config register indexes
  localparam logic REG_CH3 = 1'b0;
  localparam logic REG_CH4 = 1'b1;

  // Command bytes
  localparam logic [7:0] CMD_SYNC   = 8'h3F; // '?'
  localparam logic [7:0] CMD_START  = 8'h41; // 'A'
  localparam logic [7:0] CMD_STOP   = 8'h53; // 'S'
  localparam logic [7:0] CMD_PAUSE  = 8'h50; // 'P'

  // Frame characters
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // Decimal conversion sizes
  localparam int CONV_BITS = 16;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W = 4 * BCD_DIGITS;

  // Reply text, right aligned in 16 bytes
  localparam logic [127:0] TEXT_SYNC = "#!#4#\r\n";
  localparam logic [127:0] TEXT_DISC = "#DISCONNECTED#\r\n";
  localparam logic [127:0] TEXT_STOP = "#STOP#\r\n";

  // Index of the final byte of each reply
  function automatic logic [3:0] reply_last_idx(input reply_t sel);
    logic [3:0] r;
    case (sel)
      REPLY_SYNC: r = 4'd6;
      REPLY_DISC: r = 4'd15;
      REPLY_STOP: r = 4'd7;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  // Byte idx (from the start) of a reply
  function automatic logic [7:0] reply_byte(input reply_t sel, input logic [3:0] idx);
    logic [127:0] text;
    logic [3:0]   pos;
    case (sel)
      REPLY_SYNC: text = TEXT_SYNC;
      REPLY_DISC: text = TEXT_DISC;
      REPLY_STOP: text = TEXT_STOP;
      default:    text = '0;
    endcase
    pos = reply_last_idx(sel) - idx;
    return text[{pos, 3'b000} +: 8];
  endfunction

endpackage

FILE: hdl/telemetry_link_frame_emitter.sv
// Telemetry link frame emitter: link command machine, fixed replies and decimal
// data frames from one shared shift-and-add-3 converter. Depends on tlfe_pkg.
// A reply is sent one byte per cycle while the output is free (7, 16 or 8 bytes);
// a frame converts each of its 5 fields in turn and sends its digits. The next item
// is taken in the idle state after the last byte issues. Sync reset: wait-for-sync,
// holds and channels zero.
module telemetry_link_frame_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlfe_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlfe_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  tlfe_pkg::state_t state, state_next;
  tlfe_pkg::link_t  link, link_new;
  tlfe_pkg::reply_t reply_sel, sel_new;
  tlfe_pkg::field_t field;

  logic [3:0]  idx;
  logic [3:0]  cnt;
  logic [2:0]  dptr;
  logic [4:0]  n_sum;
  logic [7:0]  hum_hold, temp_hold;
  logic [15:0] ch3, ch4;
  logic [tlfe_pkg::BCD_W-1:0]     bcd, bcd_adj;
  logic [tlfe_pkg::CONV_BITS-1:0] bin, field_val;
  logic [2:0]  top;
  logic        reply_go;
  logic        cmd_ok;
  logic        slot_free;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;

  assign in_ready  = (state == tlfe_pkg::ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Command decode against the current link state
  always_comb begin
    cmd_ok   = in_data.rx_valid && (in_data.rx_byte != 8'd0);
    link_new = link;
    sel_new  = tlfe_pkg::REPLY_SYNC;
    reply_go = 1'b0;
    if (cmd_ok) begin
      case (link)
        tlfe_pkg::LINK_WAIT: begin
          if (in_data.rx_byte == tlfe_pkg::CMD_SYNC) begin
            link_new = tlfe_pkg::LINK_IDLE;
            reply_go = 1'b1;
          end
        end
        tlfe_pkg::LINK_IDLE: begin
          if (in_data.rx_byte == tlfe_pkg::CMD_START) begin
            link_new = tlfe_pkg::LINK_STREAM;
          end else if (in_data.rx_byte == tlfe_pkg::CMD_PAUSE) begin
            link_new = tlfe_pkg::LINK_WAIT;
            sel_new  = tlfe_pkg::REPLY_DISC;
            reply_go = 1'b1;
          end
        end
        tlfe_pkg::LINK_STREAM: begin
          if (in_data.rx_byte == tlfe_pkg::CMD_STOP) begin
            link_new = tlfe_pkg::LINK_IDLE;
            sel_new  = tlfe_pkg::REPLY_STOP;
            reply_go = 1'b1;
          end else if (in_data.rx_byte == tlfe_pkg::CMD_PAUSE) begin
            link_new = tlfe_pkg::LINK_WAIT;
            sel_new  = tlfe_pkg::REPLY_DISC;
            reply_go = 1'b1;
          end
        end
        default: begin
          link_new = link;
        end
      endcase
    end
  end

  // Value of the field being converted
  always_comb begin
    case (field)
      tlfe_pkg::FLD_HUM:   field_val = {8'd0, hum_hold};
      tlfe_pkg::FLD_TEMP:  field_val = {8'd0, temp_hold};
      tlfe_pkg::FLD_CH3:   field_val = ch3;
      tlfe_pkg::FLD_CH4:   field_val = ch4;
      tlfe_pkg::FLD_COUNT: field_val = {11'd0, n_sum};
      default:             field_val = '0;
    endcase
  end

  // Shared converter: add 3 to every BCD digit of 5 or more before each shift
  always_comb begin
    for (int i = 0; i < tlfe_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Position of the leading nonzero digit (zero shows as one digit)
  always_comb begin
    top = 3'd0;
    for (int i = 0; i < tlfe_pkg::BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        top = 3'(i);
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and byte to send
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_byte  = tlfe_pkg::CHAR_HASH;
    emit_last  = 1'b0;
    case (state)
      tlfe_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (reply_go) begin
            state_next = tlfe_pkg::ST_REPLY;
          end else if (link_new == tlfe_pkg::LINK_STREAM) begin
            state_next = tlfe_pkg::ST_PREFIX;
          end
        end
      end
      tlfe_pkg::ST_REPLY: begin
        emit_byte = tlfe_pkg::reply_byte(reply_sel, idx);
        emit_last = (idx == tlfe_pkg::reply_last_idx(reply_sel));
        if (slot_free) begin
          emit = 1'b1;
          if (emit_last) begin
            state_next = tlfe_pkg::ST_IDLE;
          end
        end
      end
      tlfe_pkg::ST_PREFIX: begin
        emit_byte = (idx == 4'd1) ? tlfe_pkg::CHAR_D : tlfe_pkg::CHAR_HASH;
        if (slot_free) begin
          emit = 1'b1;
          if (idx == 4'd2) begin
            state_next = tlfe_pkg::ST_LOAD;
          end
        end
      end
      tlfe_pkg::ST_LOAD: begin
        state_next = tlfe_pkg::ST_CONV;
      end
      tlfe_pkg::ST_CONV: begin
        if (cnt == 4'(tlfe_pkg::CONV_BITS - 1)) begin
          state_next = tlfe_pkg::ST_SCAN;
        end
      end
      tlfe_pkg::ST_SCAN: begin
        state_next = tlfe_pkg::ST_DIGIT;
      end
      tlfe_pkg::ST_DIGIT: begin
        emit_byte = tlfe_pkg::CHAR_ZERO + {4'd0, bcd[{dptr, 2'b00} +: 4]};
        if (slot_free) begin
          emit = 1'b1;
          if (dptr == 3'd0) begin
            state_next = tlfe_pkg::ST_SEP;
          end
        end
      end
      tlfe_pkg::ST_SEP: begin
        // the count field is followed by '#', then a closing newline
        if (field == tlfe_pkg::FLD_COUNT && idx == 4'd1) begin
          emit_byte = tlfe_pkg::CHAR_NL;
          emit_last = 1'b1;
        end
        if (slot_free) begin
          emit = 1'b1;
          if (field != tlfe_pkg::FLD_COUNT) begin
            state_next = tlfe_pkg::ST_LOAD;
          end else if (idx == 4'd1) begin
            state_next = tlfe_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = tlfe_pkg::ST_IDLE;
      end
    endcase
  end

  // Link state, holds and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link      <= tlfe_pkg::LINK_WAIT;
      hum_hold  <= 8'd0;
      temp_hold <= 8'd0;
      ch3       <= 16'd0;
      ch4       <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tlfe_pkg::REG_CH3: ch3 <= cfg_data;
          tlfe_pkg::REG_CH4: ch4 <= cfg_data;
          default: ;
        endcase
      end
      if (state == tlfe_pkg::ST_IDLE && in_valid) begin
        link <= link_new;
        if (link_new == tlfe_pkg::LINK_STREAM && in_data.sensor_ok) begin
          hum_hold  <= in_data.humidity;
          temp_hold <= in_data.temperature;
        end
      end
    end
  end

  // Sequencer counters and converter datapath
  always_ff @(posedge clk) begin
    case (state)
      tlfe_pkg::ST_IDLE: begin
        reply_sel <= sel_new;
        idx       <= 4'd0;
        field     <= tlfe_pkg::FLD_HUM;
        n_sum     <= 5'd0;
      end
      tlfe_pkg::ST_REPLY, tlfe_pkg::ST_PREFIX: begin
        if (slot_free) begin
          idx <= idx + 4'd1;
        end
      end
      tlfe_pkg::ST_LOAD: begin
        bcd <= '0;
        bin <= field_val;
        cnt <= 4'd0;
        idx <= 4'd0;
      end
      tlfe_pkg::ST_CONV: begin
        bcd <= {bcd_adj[tlfe_pkg::BCD_W-2:0], bin[tlfe_pkg::CONV_BITS-1]};
        bin <= {bin[tlfe_pkg::CONV_BITS-2:0], 1'b0};
        cnt <= cnt + 4'd1;
      end
      tlfe_pkg::ST_SCAN: begin
        dptr <= top;
        if (field != tlfe_pkg::FLD_COUNT) begin
          n_sum <= n_sum + 5'(top) + 5'd1;
        end
      end
      tlfe_pkg::ST_DIGIT: begin
        if (slot_free) begin
          dptr <= dptr - 3'd1;
        end
      end
      tlfe_pkg::ST_SEP: begin
        if (slot_free) begin
          idx <= idx + 4'd1;
          if (field != tlfe_pkg::FLD_COUNT) begin
            field <= tlfe_pkg::field_t'(field + 3'd1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: holds one beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.tx_byte <= emit_byte;
      out_data.last    <= emit_last;
    end
  end

endmodule
